/* sv/tcs_pkg.sv */
// Package: shared constants, types and controller commands for the column mapper.
package tcs_pkg;

   localparam int TEX_BYTES   = 65536;
   localparam int TEX_AW      = $clog2(TEX_BYTES);
   localparam int MAX_TEX_DIM = 1024;
   localparam int DIM_W       = 11;
   localparam int ROW_W       = $clog2(MAX_TEX_DIM);
   localparam int ACC_W       = 48;
   localparam int Q_W         = ACC_W - 8;
   localparam int DIV_CNT_W   = $clog2(Q_W + 1);
   localparam int PAL_DEPTH   = 256;

   localparam logic [1:0] OP_TEX_WR  = 2'd0;
   localparam logic [1:0] OP_PAL_WR  = 2'd1;
   localparam logic [1:0] OP_SPAN    = 2'd2;
   localparam logic [1:0] OP_ROW     = 2'd3;

   localparam logic [7:0] TEXEL_CLEAR = 8'hFF;
   localparam logic [8:0] SHADE_MAX   = 9'd256;
   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COL_DIV,
      ST_ROW_DIV,
      ST_ADDR,
      ST_TEX,
      ST_PAL,
      ST_SHADE
   } state_type;

   typedef struct packed {
      logic tex_wr;
      logic pal_wr;
      logic span_load;
      logic span_kill;
      logic div_load;
      logic div_col;
      logic col_store;
      logic addr_calc;
      logic tex_rd;
      logic pal_rd;
      logic shade_out;
   } cmd_type;

   typedef struct packed {
      logic span_ok;
      logic pal_ok;
      logic span_active;
      logic mask_mode;
      logic div_done;
   } status_type;

endpackage

/* sv/textured_column_span.sv */
// Top level: textured column mapper, controller plus datapath.
// Usage:
//  An item is taken when start is high and busy is low; req_op selects a
//  texel write, a palette write, a span start or a row step.
//  Texel and palette writes complete at the accepting edge; busy stays low.
//  A valid span start runs the serial remainder unit to wrap the column;
//  busy stays high until it is done. A rejected span kills the span.
//  A row step gives one result beat on rsp_* marked by rsp_valid for one
//  cycle: in wall mode after the serial remainder for the row wrap, then
//  address, texture read, palette read and shade; masked mode skips the
//  remainder unit.
//  A row step with no active span gives no beat; busy stays low.
//  The rate is one item at a time, set by the remainder unit and the two
//  dependent memory reads.
//  The receiver cannot stall; each beat shows for exactly one cycle and a
//  new item may be accepted in that cycle.
//  Synchronous reset returns to idle with no span; memories keep contents.
module textured_column_span (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_op,
   input  logic [15:0]        req_addr,
   input  logic [23:0]        req_data,
   input  logic [10:0]        req_tex_width,
   input  logic [10:0]        req_tex_height,
   input  logic signed [15:0] req_column,
   input  logic signed [31:0] req_v_start,
   input  logic signed [31:0] req_v_step,
   input  logic [15:0]        req_shade_level,
   input  logic               req_masked,
   output logic               rsp_valid,
   output logic [15:0]        rsp_row_offset,
   output logic [31:0]        rsp_pixel_color,
   output logic               rsp_opaque
);
   import tcs_pkg::*;

   cmd_type    cmd;
   status_type status;

   tcs_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_op),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   tcs_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_addr        (req_addr),
      .req_data        (req_data),
      .req_tex_width   (req_tex_width),
      .req_tex_height  (req_tex_height),
      .req_column      (req_column),
      .req_v_start     (req_v_start),
      .req_v_step      (req_v_step),
      .req_shade_level (req_shade_level),
      .req_masked      (req_masked),
      .rsp_valid       (rsp_valid),
      .rsp_row_offset  (rsp_row_offset),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_opaque      (rsp_opaque)
   );

endmodule

/* sv/tcs_ctrl.sv */
// Controller: sequences writes, span setup and the per-row sampling steps.
module tcs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [1:0]          req_op,
   input  tcs_pkg::status_type status,
   output tcs_pkg::cmd_type    cmd,
   output logic                busy
);
   import tcs_pkg::*;

   state_type state_ff, state_in;
   logic      accept;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_SPAN: begin
                     if (status.span_ok) state_in = ST_COL_DIV;
                  end
                  OP_ROW: begin
                     if (status.span_active) begin
                        state_in = status.mask_mode ? ST_ADDR : ST_ROW_DIV;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_COL_DIV: begin
            if (status.div_done) state_in = ST_IDLE;
         end
         ST_ROW_DIV: begin
            if (status.div_done) state_in = ST_ADDR;
         end
         ST_ADDR:  state_in = ST_TEX;
         ST_TEX:   state_in = ST_PAL;
         ST_PAL:   state_in = ST_SHADE;
         ST_SHADE: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_TEX_WR: cmd.tex_wr = 1'b1;
                  OP_PAL_WR: cmd.pal_wr = status.pal_ok;
                  OP_SPAN: begin
                     cmd.span_load = status.span_ok;
                     cmd.span_kill = !status.span_ok;
                     cmd.div_load  = status.span_ok;
                     cmd.div_col   = 1'b1;
                  end
                  OP_ROW: cmd.div_load = status.span_active && !status.mask_mode;
                  default: cmd = '0;
               endcase
            end
         end
         ST_COL_DIV: cmd.col_store = status.div_done;
         ST_ADDR:    cmd.addr_calc = 1'b1;
         ST_TEX:     cmd.tex_rd    = 1'b1;
         ST_PAL:     cmd.pal_rd    = 1'b1;
         ST_SHADE:   cmd.shade_out = 1'b1;
         default:    cmd = '0;
      endcase
   end

endmodule

/* sv/tcs_datapath.sv */
// Datapath: texture and palette memories, span state, serial modulo unit, shading.
module tcs_datapath (
   input  logic                clock,
   input  logic                reset,
   input  tcs_pkg::cmd_type    cmd,
   output tcs_pkg::status_type status,
   input  logic [15:0]         req_addr,
   input  logic [23:0]         req_data,
   input  logic [10:0]         req_tex_width,
   input  logic [10:0]         req_tex_height,
   input  logic signed [15:0]  req_column,
   input  logic signed [31:0]  req_v_start,
   input  logic signed [31:0]  req_v_step,
   input  logic [15:0]         req_shade_level,
   input  logic                req_masked,
   output logic                rsp_valid,
   output logic [15:0]         rsp_row_offset,
   output logic [31:0]         rsp_pixel_color,
   output logic                rsp_opaque
);
   import tcs_pkg::*;

   logic [7:0]  tex_mem [TEX_BYTES];
   logic [23:0] pal_mem [PAL_DEPTH];

   logic [ACC_W-1:0] accum_ff;
   logic [31:0]      step_ff;
   logic [ROW_W-1:0] colbase_ff;
   logic [DIM_W-1:0] height_ff;
   logic [8:0]       shade_ff;
   logic             mask_ff;
   logic [15:0]      rowcnt_ff;
   logic             active_ff;

   // serial remainder unit
   logic [Q_W-1:0]       dd_ff;
   logic [DIM_W-1:0]     rem_ff;
   logic [DIM_W-1:0]     dvs_ff;
   logic                 neg_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIM_W:0]       trial;
   logic [DIM_W-1:0]     mod_res;

   logic [TEX_AW-1:0] taddr_ff;
   logic              inrange_ff;
   logic [7:0]        texel_ff;
   logic [23:0]       pal_q_ff;
   logic              clear_ff;

   logic [21:0]          area;
   logic                 span_ok;
   logic signed [Q_W-1:0] q;
   logic [Q_W-1:0]        q_mag;
   logic [15:0]           col_mag;
   logic [21:0]           base;
   logic [21:0]           taddr_sum;
   logic [ROW_W-1:0]      row_sel;
   logic                  q_inrange;
   logic [16:0]           r_prod, g_prod, b_prod;

   assign area    = 22'(req_tex_width) * 22'(req_tex_height);
   assign span_ok = (req_tex_width != '0) && (req_tex_height != '0) &&
                    (req_tex_width <= DIM_W'(MAX_TEX_DIM)) &&
                    (req_tex_height <= DIM_W'(MAX_TEX_DIM)) &&
                    (area <= 22'(TEX_BYTES));

   assign status.span_ok     = span_ok;
   assign status.pal_ok      = (req_addr < 16'(PAL_DEPTH));
   assign status.span_active = active_ff;
   assign status.mask_mode   = mask_ff;
   assign status.div_done    = (cnt_ff == '0);

   assign q       = accum_ff[ACC_W-1:8];
   assign q_mag   = q[Q_W-1] ? Q_W'(-q) : Q_W'(q);
   assign col_mag = req_column[15] ? 16'(-req_column) : 16'(req_column);

   // restoring step: shift one dividend bit into the remainder
   assign trial   = {rem_ff, dd_ff[Q_W-1]};
   assign mod_res = (neg_ff && rem_ff != '0) ? DIM_W'(dvs_ff - rem_ff) : rem_ff;

   assign q_inrange = !q[Q_W-1] && (q < Q_W'(height_ff));
   assign row_sel   = mask_ff ? q[ROW_W-1:0] : mod_res[ROW_W-1:0];
   assign base      = 22'(colbase_ff) * 22'(height_ff);
   assign taddr_sum = base + 22'(row_sel);

   assign r_prod = pal_q_ff[7:0]   * shade_ff;
   assign g_prod = pal_q_ff[15:8]  * shade_ff;
   assign b_prod = pal_q_ff[23:16] * shade_ff;

   always_ff @(posedge clock) begin
      if (cmd.tex_wr) tex_mem[req_addr[TEX_AW-1:0]] <= req_data[7:0];
      if (cmd.tex_rd) texel_ff <= tex_mem[taddr_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.pal_wr) pal_mem[req_addr[7:0]] <= req_data;
      if (cmd.pal_rd) pal_q_ff <= pal_mem[texel_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff   <= '0;
         step_ff    <= '0;
         colbase_ff <= '0;
         height_ff  <= DIM_W'(1);
         shade_ff   <= '0;
         mask_ff    <= 1'b0;
         rowcnt_ff  <= '0;
         active_ff  <= 1'b0;
         cnt_ff     <= '0;
         rsp_valid  <= 1'b0;
      end else begin
         rsp_valid <= cmd.shade_out;
         if (cmd.span_kill) active_ff <= 1'b0;
         if (cmd.span_load) begin
            accum_ff  <= ACC_W'(req_v_start);
            step_ff   <= req_v_step;
            height_ff <= req_tex_height;
            shade_ff  <= (req_shade_level > 16'(SHADE_MAX)) ? SHADE_MAX
                                                            : req_shade_level[8:0];
            mask_ff   <= req_masked;
            rowcnt_ff <= '0;
            active_ff <= 1'b1;
         end
         if (cmd.col_store) colbase_ff <= mod_res[ROW_W-1:0];
         if (cmd.shade_out) begin
            accum_ff  <= accum_ff + ACC_W'(signed'(step_ff));
            rowcnt_ff <= rowcnt_ff + 16'd1;
         end
         if (cmd.div_load) begin
            cnt_ff <= DIV_CNT_W'(Q_W);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - DIV_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rem_ff <= '0;
         if (cmd.div_col) begin
            dd_ff  <= Q_W'(col_mag);
            neg_ff <= req_column[15];
            dvs_ff <= req_tex_width;
         end else begin
            dd_ff  <= q_mag;
            neg_ff <= q[Q_W-1];
            dvs_ff <= height_ff;
         end
      end else if (cnt_ff != '0) begin
         dd_ff  <= {dd_ff[Q_W-2:0], 1'b0};
         rem_ff <= (trial >= {1'b0, dvs_ff}) ? DIM_W'(trial - {1'b0, dvs_ff})
                                              : DIM_W'(trial);
      end
      if (cmd.addr_calc) begin
         taddr_ff   <= taddr_sum[TEX_AW-1:0];
         inrange_ff <= mask_ff ? q_inrange : 1'b1;
      end
      if (cmd.pal_rd) clear_ff <= !inrange_ff || (mask_ff && texel_ff == TEXEL_CLEAR);
      if (cmd.shade_out) begin
         rsp_row_offset <= rowcnt_ff;
         rsp_opaque     <= !clear_ff;
         rsp_pixel_color <= clear_ff ? 32'd0
                           : {ALPHA_OPAQUE, b_prod[15:8], g_prod[15:8], r_prod[15:8]};
      end
   end

endmodule
